@@ rtl/core/flbp_pkg.sv @@
package flbp_pkg;

  localparam int NUM_BLOCKS = 256;
  localparam int LINK_DEPTH = 256;
  localparam int POOL_COUNT = (NUM_BLOCKS > LINK_DEPTH) ? LINK_DEPTH : NUM_BLOCKS;

  localparam int IDX_W  = 8;
  localparam int CNT_W  = 9;
  localparam int BS_W   = 13;
  localparam int OFF_W  = 20;
  localparam int BYTE_W = 21;

  localparam logic [BS_W-1:0] BLOCK_SIZE_RST = BS_W'(64);

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_RESET = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_NONE_OUT  = 2'd2;
  localparam logic [1:0] ST_NULL_FREE = 2'd3;

  localparam logic [2:0] REG_BLOCK_SIZE = 3'd0;

  typedef enum logic {
    S_IDLE,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] wr_data;
    logic             clr;
  } link_req_t;

endpackage

@@ rtl/core/flbp_cfg.sv @@
module flbp_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [flbp_pkg::BS_W-1:0]     block_size
);

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr == flbp_pkg::REG_BLOCK_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= flbp_pkg::BLOCK_SIZE_RST;
    end else if (wr_hit) begin
      block_size <= pwdata[flbp_pkg::BS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == flbp_pkg::REG_BLOCK_SIZE) begin
      prdata = {{(32 - flbp_pkg::BS_W){1'b0}}, block_size};
    end
  end

endmodule

@@ rtl/core/flbp_link_store.sv @@
module flbp_link_store (
  input  logic                           clk,
  input  logic                           rst,
  input  flbp_pkg::link_req_t            req,
  output logic [flbp_pkg::IDX_W-1:0]     rd_data
);

  logic [flbp_pkg::IDX_W-1:0] mem [flbp_pkg::LINK_DEPTH];
  logic [flbp_pkg::LINK_DEPTH-1:0] valid;
  logic [flbp_pkg::IDX_W-1:0] mem_rd;
  logic [flbp_pkg::IDX_W-1:0] addr_rd;
  logic                       valid_rd;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_rd <= mem[req.rd_addr];
    end
  end

  // entries never written since a rebuild read as their default link
  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      addr_rd  <= req.rd_addr;
      valid_rd <= valid[req.rd_addr];
    end
  end

  assign rd_data = valid_rd ? mem_rd : addr_rd + flbp_pkg::IDX_W'(1);

endmodule

@@ rtl/core/flbp_ctrl.sv @@
module flbp_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,
  input  logic [2:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [71:0]                     m_tdata,
  output logic [1:0]                      m_tuser,
  input  logic [flbp_pkg::BS_W-1:0]       block_size,
  output flbp_pkg::link_req_t             link_req,
  input  logic [flbp_pkg::IDX_W-1:0]      link_rd
);

  flbp_pkg::state_t state, state_next;

  logic [flbp_pkg::IDX_W-1:0] head, head_next;
  logic [flbp_pkg::CNT_W-1:0] free_total, free_total_next;
  logic [flbp_pkg::CNT_W-1:0] used_total, used_total_next;

  logic [1:0]                 func_q;
  logic                       has_q;
  logic [flbp_pkg::IDX_W-1:0] idx_q;

  logic [1:0]                 status;
  logic [flbp_pkg::IDX_W-1:0] given;
  logic [flbp_pkg::BYTE_W-1:0] off_prod;
  logic [flbp_pkg::BYTE_W:0]   bytes_prod;

  logic accept;
  logic finish;

  assign s_tready = (state == flbp_pkg::S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign finish   = (state == flbp_pkg::S_UPDATE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= flbp_pkg::S_IDLE;
      head       <= '0;
      free_total <= flbp_pkg::CNT_W'(flbp_pkg::POOL_COUNT);
      used_total <= '0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      free_total <= free_total_next;
      used_total <= used_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= s_tuser[1:0];
      has_q  <= s_tuser[2];
      idx_q  <= s_tdata;
    end
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    free_total_next = free_total;
    used_total_next = used_total;
    status          = flbp_pkg::ST_OK;
    given           = '0;
    link_req        = '0;
    link_req.rd_addr = head;
    link_req.wr_addr = idx_q;
    link_req.wr_data = head;
    unique case (state)
      flbp_pkg::S_IDLE: begin
        link_req.rd_en = accept;
        if (accept) begin
          state_next = flbp_pkg::S_UPDATE;
        end
      end
      flbp_pkg::S_UPDATE: begin
        case (func_q)
          flbp_pkg::FUNC_ALLOC: begin
            if (free_total == '0) begin
              status = flbp_pkg::ST_EXHAUSTED;
            end else begin
              given           = head;
              head_next       = link_rd;
              free_total_next = free_total - flbp_pkg::CNT_W'(1);
              used_total_next = used_total + flbp_pkg::CNT_W'(1);
            end
          end
          flbp_pkg::FUNC_FREE: begin
            if (!has_q || ({1'b0, idx_q} >= flbp_pkg::CNT_W'(flbp_pkg::POOL_COUNT))) begin
              status = flbp_pkg::ST_NULL_FREE;
            end else if (used_total == '0) begin
              status = flbp_pkg::ST_NONE_OUT;
            end else begin
              link_req.wr_en  = 1'b1;
              head_next       = idx_q;
              free_total_next = free_total + flbp_pkg::CNT_W'(1);
              used_total_next = used_total - flbp_pkg::CNT_W'(1);
            end
          end
          flbp_pkg::FUNC_RESET: begin
            link_req.clr    = 1'b1;
            head_next       = '0;
            free_total_next = flbp_pkg::CNT_W'(flbp_pkg::POOL_COUNT);
            used_total_next = '0;
          end
          default: begin
          end
        endcase
        if (finish) begin
          state_next = flbp_pkg::S_IDLE;
        end else begin
          head_next       = head;
          free_total_next = free_total;
          used_total_next = used_total;
          link_req.wr_en  = 1'b0;
          link_req.clr    = 1'b0;
        end
      end
      default: begin
        state_next = flbp_pkg::S_IDLE;
      end
    endcase
  end

  assign off_prod   = flbp_pkg::BYTE_W'(given) * flbp_pkg::BYTE_W'(block_size);
  assign bytes_prod = (flbp_pkg::BYTE_W + 1)'(used_total_next) *
                      (flbp_pkg::BYTE_W + 1)'(block_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tuser <= status;
      m_tdata <= {5'b0,
                  bytes_prod[flbp_pkg::BYTE_W-1:0],
                  used_total_next,
                  free_total_next,
                  off_prod[flbp_pkg::OFF_W-1:0],
                  given};
    end
  end

endmodule

@@ rtl/core/free_list_block_pool.sv @@
// Fixed-size block pool allocator with a LIFO free list of 256 blocks. Each input
// transaction is one request: allocate pops the head block and returns its index
// and byte offset (index times block_size), free pushes the given index back as the
// new head, reset rebuilds the list so blocks come out as 0, 1, 2 and so on. Every
// request returns one result transaction with a status code and the free count,
// used count and bytes in use after the request. In a request, the accept cycle
// reads the next link of the head block from the link memory, whose read data is
// registered, and the following cycle updates the list and loads the output
// register; that cycle repeats while the output register is full and m_tready is
// low. The link memory needs no clearing pass after reset or a pool reset:
// entries not yet written since then read as their default link. block_size
// is written over the APB port at address 0 and should only change while idle.
module free_list_block_pool (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // block_index[7:0]
  input  logic [2:0]  s_tuser,   // func[1:0], has_block[2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // given_block[7:0], byte_offset[27:8],
                                 // blocks_free[36:28], blocks_used[45:37],
                                 // bytes_used[66:46], zero[71:67]
  output logic [1:0]  m_tuser,   // status[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [flbp_pkg::BS_W-1:0]  block_size;
  flbp_pkg::link_req_t        link_req;
  logic [flbp_pkg::IDX_W-1:0] link_rd;

  flbp_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .block_size (block_size)
  );

  flbp_link_store u_link (
    .clk     (clk),
    .rst     (rst),
    .req     (link_req),
    .rd_data (link_rd)
  );

  flbp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .block_size (block_size),
    .link_req   (link_req),
    .link_rd    (link_rd)
  );

endmodule

@@ rtl/core/flbp_checker.sv @@
module flbp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic [2:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a request is in flight");

  // every block is either free or outstanding
  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, m_tdata[36:28]} + {1'b0, m_tdata[45:37]} ==
                  10'(flbp_pkg::POOL_COUNT)))
    else $error("free and used counts do not add up to the pool size");

  // exhausted means nothing free and no block or offset given
  a_exhausted: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == flbp_pkg::ST_EXHAUSTED) |->
      (m_tdata[36:28] == 9'd0 && m_tdata[7:0] == 8'd0 && m_tdata[27:8] == 20'd0))
    else $error("exhausted result with free blocks or a given block");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed while stalled");

endmodule

bind free_list_block_pool flbp_checker u_flbp_checker (.*);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam logic [2:0] BS_ADDR = 3'(4 * flbp_pkg::REG_BLOCK_SIZE);
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  given;
    logic [19:0] offset;
    logic [8:0]  nfree;
    logic [8:0]  nused;
    logic [20:0] bytes;
  } pool_result_t;

  class pool_tracker;
    logic [7:0] link_mem [256];
    logic [7:0] head;
    int unsigned free_cnt;
    int unsigned used_cnt;
    logic [12:0] blk_size;
    pool_result_t exp_q[$];
    logic [7:0] held[$];
    int unsigned errors;
    int unsigned n_req;
    int unsigned n_res;
    int unsigned n_exhausted;
    int unsigned n_none_out;

    function new();
      blk_size = flbp_pkg::BLOCK_SIZE_RST;
      rebuild();
    endfunction

    function void rebuild();
      for (int i = 0; i < 256; i++) link_mem[i] = 8'(i + 1);
      head = '0;
      free_cnt = flbp_pkg::POOL_COUNT;
      used_cnt = 0;
      held.delete();
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_res);
      errors++;
    endtask

    function void note_request(logic [1:0] fn, logic has, logic [7:0] idx);
      pool_result_t r;
      int unsigned prod;
      r = '0;
      case (fn)
        flbp_pkg::FUNC_ALLOC: begin
          if (free_cnt == 0) begin
            r.status = flbp_pkg::ST_EXHAUSTED;
            n_exhausted++;
          end else begin
            r.given = head;
            head = link_mem[r.given];
            free_cnt--;
            used_cnt++;
            prod = 32'(r.given) * 32'(blk_size);
            r.offset = prod[19:0];
            held.push_back(r.given);
          end
        end
        flbp_pkg::FUNC_FREE: begin
          if (!has || 32'(idx) >= flbp_pkg::POOL_COUNT) begin
            r.status = flbp_pkg::ST_NULL_FREE;
          end else if (used_cnt == 0) begin
            r.status = flbp_pkg::ST_NONE_OUT;
            n_none_out++;
          end else begin
            link_mem[idx] = head;
            head = idx;
            free_cnt++;
            used_cnt--;
            foreach (held[j]) begin
              if (held[j] == idx) begin
                held.delete(j);
                break;
              end
            end
          end
        end
        flbp_pkg::FUNC_RESET: rebuild();
        default: ;
      endcase
      r.nfree = 9'(free_cnt);
      r.nused = 9'(used_cnt);
      prod = used_cnt * 32'(blk_size);
      r.bytes = prod[20:0];
      exp_q.push_back(r);
      n_req++;
    endfunction

    task check_result(pool_result_t got);
      pool_result_t e;
      if (exp_q.size() == 0) begin
        report_mismatch("unexpected result, status", got.status, 0);
        return;
      end
      e = exp_q.pop_front();
      if (got.status !== e.status) report_mismatch("status", got.status, e.status);
      if (got.given !== e.given) report_mismatch("given_block", got.given, e.given);
      if (got.offset !== e.offset) report_mismatch("byte_offset", got.offset, e.offset);
      if (got.nfree !== e.nfree) report_mismatch("blocks_free", got.nfree, e.nfree);
      if (got.nused !== e.nused) report_mismatch("blocks_used", got.nused, e.nused);
      if (got.bytes !== e.bytes) report_mismatch("bytes_used", got.bytes, e.bytes);
      n_res++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // block_index[7:0]
  logic [2:0]  s_tuser = '0;   // func[1:0], has_block[2]
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [71:0] m_tdata;       // given_block, byte_offset, blocks_free, blocks_used, bytes_used
  logic [1:0]  m_tuser;       // status[1:0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pool_tracker sb = new();
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_req = 1'b0;
  int unsigned cycle_cnt = 0;

  free_list_block_pool uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt, sb.exp_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        sb.check_result({m_tuser, m_tdata[7:0], m_tdata[27:8], m_tdata[36:28],
                         m_tdata[45:37], m_tdata[66:46]});
      if (s_tvalid && s_tready) sb.note_request(s_tuser[1:0], s_tuser[2], s_tdata);
    end
  end

  // sink side: random stall bursts plus one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        m_tready <= 1'b1;
      end else if (rx_idle && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_req(input logic [1:0] fn, input logic has, input logic [7:0] idx);
    if (tx_idle && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_tuser <= {has, fn};
    s_tdata <= idx;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.exp_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_block_size(input logic [12:0] bs);
    logic [31:0] rd;
    reg_access(1'b1, BS_ADDR, {19'd0, bs}, rd);
    sb.blk_size = bs;
    reg_access(1'b0, BS_ADDR, '0, rd);
    if (rd !== {19'd0, bs}) sb.report_mismatch("block_size readback", rd, bs);
  endtask

  task automatic run_traffic(input int n);
    int count;
    int r;
    int k;
    logic [7:0] idx;
    count = 0;
    while (count < n) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        k = (r < 3) ? 260 : $urandom_range(1, 24);
        repeat (k) send_req(flbp_pkg::FUNC_ALLOC, 1'($urandom), 8'($urandom));
        count += k;
      end else if (r < 80) begin
        k = $urandom_range(1, 24);
        repeat (k) begin
          if (sb.held.size() > 0) idx = sb.held[$urandom_range(0, sb.held.size() - 1)];
          else idx = 8'($urandom);
          send_req(flbp_pkg::FUNC_FREE, 1'b1, idx);
        end
        count += k;
      end else if (r < 96) begin
        send_req(2'($urandom), 1'($urandom), 8'($urandom));
      end else begin
        send_req(flbp_pkg::FUNC_RESET, 1'($urandom), 8'($urandom));
        count++;
      end
    end
  endtask

  initial begin
    logic [12:0] rand_bs;
    rand_bs = 13'($urandom_range(8, 4096));
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_req(flbp_pkg::FUNC_ALLOC, 1'b0, 8'h00);
    send_req(flbp_pkg::FUNC_ALLOC, 1'b1, 8'hFF);
    send_req(flbp_pkg::FUNC_ALLOC, 1'b0, 8'h55);
    send_req(flbp_pkg::FUNC_FREE, 1'b1, 8'd1);
    send_req(flbp_pkg::FUNC_ALLOC, 1'b1, 8'hAA);
    send_req(flbp_pkg::FUNC_FREE, 1'b0, 8'hAA);
    send_req(FUNC_NONE, 1'b1, 8'hFF);
    send_req(flbp_pkg::FUNC_FREE, 1'b1, 8'd255);
    send_req(flbp_pkg::FUNC_ALLOC, 1'b0, 8'h00);
    send_req(flbp_pkg::FUNC_FREE, 1'b1, 8'd0);
    send_req(flbp_pkg::FUNC_FREE, 1'b1, 8'd0);
    send_req(flbp_pkg::FUNC_FREE, 1'b1, 8'd2);
    send_req(flbp_pkg::FUNC_FREE, 1'b1, 8'd1);
    send_req(flbp_pkg::FUNC_FREE, 1'b1, 8'd5);
    send_req(flbp_pkg::FUNC_ALLOC, 1'b1, 8'h00);
    send_req(flbp_pkg::FUNC_ALLOC, 1'b1, 8'h00);
    send_req(flbp_pkg::FUNC_RESET, 1'b1, 8'hFF);
    send_req(flbp_pkg::FUNC_ALLOC, 1'b0, 8'h00);
    send_req(flbp_pkg::FUNC_RESET, 1'b0, 8'h00);
    send_req(flbp_pkg::FUNC_FREE, 1'b1, 8'd7);
    run_traffic(230);
    settle();

    tx_idle = 1'b1;
    rx_idle = 1'b0;
    set_block_size(13'd8);
    run_traffic(250);
    settle();

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    set_block_size(13'd4096);
    run_traffic(100);
    hold_req = 1'b1;
    run_traffic(150);
    settle();

    tx_idle = 1'b0;
    rx_idle = 1'b1;
    set_block_size(13'd8191);
    run_traffic(250);
    settle();

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    set_block_size(13'd0);
    run_traffic(150);
    settle();

    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_block_size(rand_bs);
    run_traffic(250);
    settle();

    $display("%0d requests sent, %0d results checked, %0d exhausted allocates, %0d empty frees",
             sb.n_req, sb.n_res, sb.n_exhausted, sb.n_none_out);
    $display("block sizes 64, 8, 4096, 8191, 0, %0d with random stalls and one long sink hold",
             rand_bs);
    if (sb.errors == 0 && sb.exp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/flbp_pkg.sv
rtl/core/flbp_cfg.sv
rtl/core/flbp_link_store.sv
rtl/core/flbp_ctrl.sv
rtl/core/free_list_block_pool.sv
rtl/core/flbp_checker.sv
dv/tb_top.sv
